/* sv/kds_pkg.sv */
// ----------------------------------------------------------------------------
// kds_pkg
// Shared types and constants of the keyword dictionary scorer.
// ----------------------------------------------------------------------------
package kds_pkg;

    localparam int KEY_ENTRIES_DEF   = 64;
    localparam int MAX_KEY_BYTES_DEF = 16;

    localparam logic [1:0] CMD_TEXT = 2'd0;
    localparam logic [1:0] CMD_END  = 2'd1;
    localparam logic [1:0] CMD_KEYB = 2'd2;
    localparam logic [1:0] CMD_ATTR = 2'd3;

    localparam logic [1:0] REG_OK   = 2'd0;
    localparam logic [1:0] REG_PART = 2'd1;
    localparam logic [1:0] REG_AMB  = 2'd2;
    localparam logic [1:0] REG_URG  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_INC   = 2'd1;
    localparam logic [1:0] ST_AMB   = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic [6:0] SCORE_MAX = 7'd100;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_OUT
    } t_state;

    function automatic logic [6:0] sat100(input logic [6:0] v);
        return (v > SCORE_MAX) ? SCORE_MAX : v;
    endfunction

endpackage

/* sv/kds_dict.sv */
// ----------------------------------------------------------------------------
// kds_dict
// Dictionary memories: key bytes and key attributes, one read port each with
// a registered read.
// ----------------------------------------------------------------------------
module kds_dict
    import kds_pkg::*;
#(
    parameter int KEY_ENTRIES   = KEY_ENTRIES_DEF,
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF,
    parameter int IW            = $clog2(KEY_ENTRIES),
    parameter int PW            = $clog2(MAX_KEY_BYTES)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_kwe,
    input  logic [IW-1:0]                i_kidx,
    input  logic [PW-1:0]                i_kpos,
    input  logic [7:0]                   i_kbyte,
    input  logic                         i_awe,
    input  logic [IW-1:0]                i_aidx,
    input  logic [15:0]                  i_adata,
    input  logic [IW-1:0]                i_raddr,
    output logic [MAX_KEY_BYTES*8-1:0]   o_key,
    output logic [15:0]                  o_attr
);
    logic [MAX_KEY_BYTES*8-1:0] r_keys [KEY_ENTRIES];
    logic [15:0]                r_attrs [KEY_ENTRIES];
    // Attribute valid bits: an entry never written reads as disabled.
    logic [KEY_ENTRIES-1:0]     r_avld;
    logic                       r_rvld;
    logic [15:0]                r_attr_q;

    always_ff @(posedge i_clk) begin
        if (i_kwe) begin
            r_keys[i_kidx][i_kpos*8 +: 8] <= i_kbyte;
        end
        if (i_awe) begin
            r_attrs[i_aidx] <= i_adata;
        end
        o_key    <= r_keys[i_raddr];
        r_attr_q <= r_attrs[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avld <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (i_awe) begin
                r_avld[i_aidx] <= 1'b1;
            end
            r_rvld <= r_avld[i_raddr];
        end
    end

    assign o_attr = r_rvld ? r_attr_q : 16'd0;
endmodule

/* sv/keyword_dictionary_scorer.sv */
// ----------------------------------------------------------------------------
// keyword_dictionary_scorer
// Folds text to lower case and matches the text tail against a dictionary
// of keys held in memory, reporting the running and final intent.
// ----------------------------------------------------------------------------
// Loads are taken in S_IDLE. A text or end-of-text beat is scanned in S_SCAN,
// one dictionary entry a cycle from the single read port of the memory; its
// result beat is then registered in S_OUT, which waits while an earlier result
// is still held, and the next beat is taken back in S_IDLE: no new beat is
// taken while one is being scanned. Reset is synchronous, active low, restores
// the register defaults and clears the text state.
module keyword_dictionary_scorer
    import kds_pkg::*;
#(
    parameter int KEY_ENTRIES   = KEY_ENTRIES_DEF,
    parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata from bit 0: byte_value[7:0], entry_index[13:8], char_position[17:14],
    // key_length[22:18], key_score[29:23], key_kind[32:30], key_group[33],
    // zero fill [39:34]
    input  logic [39:0] s_axis_tdata,
    // tuser: cmd
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata from bit 0: status[1:0], kind[4:2], confidence[11:5], urgency[18:12],
    // clarify_count[20:19], zero fill [23:21]
    output logic [23:0] m_axis_tdata,
    // tuser: is_final
    output logic        m_axis_tuser
);
    localparam int IW = $clog2(KEY_ENTRIES);
    localparam int PW = $clog2(MAX_KEY_BYTES);
    localparam int LW = $clog2(MAX_KEY_BYTES + 1);
    localparam int WB = MAX_KEY_BYTES * 8;

    // Input fields.
    logic [1:0] cmd;
    logic [7:0] byte_value;
    logic [5:0] entry_index;
    logic [3:0] char_position;
    assign cmd           = s_axis_tuser;
    assign byte_value    = s_axis_tdata[7:0];
    assign entry_index   = s_axis_tdata[13:8];
    assign char_position = s_axis_tdata[17:14];

    // Memory addresses of a load, sized to the dictionary.
    logic [IW-1:0] ent_idx;
    logic [PW-1:0] ent_pos;
    assign ent_idx = IW'(entry_index);
    assign ent_pos = PW'(char_position);

    t_state r_state, n_state;
    logic   in_acc;
    assign in_acc = s_axis_tvalid && s_axis_tready;

    // Configuration registers.
    logic [6:0] r_ok_th, r_part_th, r_amb_th, r_def_urg;

    // Text state.
    logic [WB-1:0]          r_window;
    logic [LW-1:0]          r_seen;
    logic                   r_nonempty;
    logic [KEY_ENTRIES-1:0] r_found;
    logic                   r_final;

    // Scan.
    logic [IW:0]   r_cnt;     // entry being addressed
    logic [IW:0]   r_chk;     // entry whose read data is present
    logic          r_chk_vld;
    logic [6:0]    r_best_sc;
    logic [2:0]    r_best_kd;
    logic          r_urg_hit;
    logic [6:0]    r_urg;

    // Results.
    logic          r_ovld;
    logic [23:0]   r_odata;
    logic          r_ofinal;

    // Dictionary.
    logic          kwe, awe;
    logic [WB-1:0] rd_key;
    logic [15:0]   rd_attr;
    logic [15:0]   adata;

    assign kwe = in_acc && cmd == CMD_KEYB && int'(entry_index) < KEY_ENTRIES
                 && int'(char_position) < MAX_KEY_BYTES;
    assign awe = in_acc && cmd == CMD_ATTR && int'(entry_index) < KEY_ENTRIES;
    // attribute word: length[4:0], score[11:5], kind[14:12], group[15]
    assign adata = {s_axis_tdata[33], s_axis_tdata[32:30],
                    sat100(s_axis_tdata[29:23]), s_axis_tdata[22:18]};

    kds_dict #(
        .KEY_ENTRIES   (KEY_ENTRIES),
        .MAX_KEY_BYTES (MAX_KEY_BYTES),
        .IW            (IW),
        .PW            (PW)
    ) u_dict (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_kwe   (kwe),
        .i_kidx  (ent_idx),
        .i_kpos  (ent_pos),
        .i_kbyte (byte_value),
        .i_awe   (awe),
        .i_aidx  (ent_idx),
        .i_adata (adata),
        .i_raddr (r_cnt[IW-1:0]),
        .o_key   (rd_key),
        .o_attr  (rd_attr)
    );

    // Attribute fields of the entry under test.
    logic [4:0] a_len;
    logic [6:0] a_sc;
    logic [2:0] a_kd;
    logic       a_grp;
    assign a_len = rd_attr[4:0];
    assign a_sc  = rd_attr[11:5];
    assign a_kd  = rd_attr[14:12];
    assign a_grp = rd_attr[15];

    // Tail compare: byte i of the key lines up with window byte
    // MAX_KEY_BYTES - len + i; the newest text byte sits in the top byte.
    logic match;
    always_comb begin
        logic ok;
        ok = 1'b1;
        for (int i = 0; i < MAX_KEY_BYTES; i++) begin
            if (i < int'(a_len)) begin
                if (rd_key[i*8 +: 8] !=
                    r_window[(MAX_KEY_BYTES - int'(a_len) + i)*8 +: 8]) begin
                    ok = 1'b0;
                end
            end
        end
        match = ok && a_len != 5'd0 && {1'b0, a_len} <= 6'(MAX_KEY_BYTES)
                && {1'b0, a_len} <= 6'(r_seen);
    end

    logic hit;
    assign hit = r_final ? r_found[r_chk[IW-1:0]]
                         : (r_found[r_chk[IW-1:0]] || match);

    // Status from a score.
    function automatic logic [1:0] status_of(input logic [6:0] s, input logic [6:0] okt,
                                             input logic [6:0] pt);
        if (s >= okt) return ST_OK;
        if (s >= pt) return ST_INC;
        return ST_AMB;
    endfunction

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc && (cmd == CMD_TEXT || cmd == CMD_END)) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (r_chk_vld && r_chk == (IW+1)'(KEY_ENTRIES - 1)) n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ovld) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // The input side is open only between items; the finished result waits
    // in its own register so the next beat can be taken while it is held.
    always_comb begin
        s_axis_tready = (r_state == S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ok_th    <= 7'd70;
            r_part_th  <= 7'd40;
            r_amb_th   <= 7'd60;
            r_def_urg  <= 7'd50;
            r_window   <= '0;
            r_seen     <= '0;
            r_nonempty <= 1'b0;
            r_found    <= '0;
            r_final    <= 1'b0;
            r_cnt      <= '0;
            r_chk      <= '0;
            r_chk_vld  <= 1'b0;
            r_ovld     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_OK:   r_ok_th   <= sat100(i_cfg_data);
                    REG_PART: r_part_th <= sat100(i_cfg_data);
                    REG_AMB:  r_amb_th  <= sat100(i_cfg_data);
                    REG_URG:  r_def_urg <= sat100(i_cfg_data);
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) r_ovld <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    r_cnt     <= '0;
                    r_chk_vld <= 1'b0;
                    if (in_acc && cmd == CMD_TEXT) begin
                        r_window <= {((byte_value >= 8'h41 && byte_value <= 8'h5A) ?
                                      byte_value + 8'd32 : byte_value),
                                     r_window[WB-1:8]};
                        if (r_seen < LW'(MAX_KEY_BYTES)) r_seen <= r_seen + 1'b1;
                        r_nonempty <= 1'b1;
                        r_final    <= 1'b0;
                    end else if (in_acc && cmd == CMD_END) begin
                        r_final <= 1'b1;
                    end
                end
                S_SCAN: begin
                    r_chk     <= r_cnt;
                    r_chk_vld <= !(r_chk_vld && r_chk == (IW+1)'(KEY_ENTRIES - 1));
                    if (r_cnt != (IW+1)'(KEY_ENTRIES)) r_cnt <= r_cnt + 1'b1;
                    if (r_chk_vld && hit) r_found[r_chk[IW-1:0]] <= 1'b1;
                end
                S_OUT: begin
                    if (!r_ovld) begin
                        r_ovld <= 1'b1;
                        if (r_final) begin
                            r_window   <= '0;
                            r_seen     <= '0;
                            r_nonempty <= 1'b0;
                            r_found    <= '0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Best intent and first urgency key gathered during the walk.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_best_sc <= '0;
            r_best_kd <= '0;
            r_urg_hit <= 1'b0;
            r_urg     <= '0;
        end else if (r_state == S_SCAN && r_chk_vld && hit) begin
            if (!a_grp && a_sc > r_best_sc) begin
                r_best_sc <= a_sc;
                r_best_kd <= a_kd;
            end
            if (a_grp && !r_urg_hit) begin
                r_urg_hit <= 1'b1;
                r_urg     <= a_sc;
            end
        end
    end

    // Result formation.
    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && !r_ovld) begin
            r_ofinal <= r_final;
            if (!r_final) begin
                r_odata <= {3'd0, 2'd0, 7'd0, r_best_sc, r_best_kd,
                            status_of(r_best_sc, r_ok_th, r_part_th)};
            end else if (!r_nonempty) begin
                r_odata <= {3'd0, 2'd0, r_def_urg, 7'd0, 3'd0, ST_EMPTY};
            end else begin
                r_odata <= {3'd0,
                            (r_best_sc < r_amb_th) ?
                                ((r_best_kd == 3'd1) ? 2'd2 : 2'd1) : 2'd0,
                            r_urg_hit ? r_urg : r_def_urg,
                            r_best_sc, r_best_kd,
                            status_of(r_best_sc, r_ok_th, r_part_th)};
            end
        end
    end

    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ofinal;
endmodule

/* test/kds_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kds_checker
// Watches both streams of the keyword dictionary scorer, keeps its own
// dictionary and text state, predicts every result beat and compares it.
// ----------------------------------------------------------------------------
module kds_checker
    import kds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [39:0] i_in_data,
    input  logic [1:0]  i_in_cmd,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [23:0] i_out_data,
    input  logic        i_out_final,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_finals_seen,
    output int          o_found_seen
);

    typedef struct packed {
        logic [1:0] status;
        logic [2:0] kind;
        logic [6:0] confidence;
        logic [6:0] urgency;
        logic [1:0] questions;
        logic       is_final;
    } t_verdict;

    logic [7:0] key_bytes [64][16];
    logic [4:0] key_len   [64];
    logic [6:0] key_pts   [64];
    logic [2:0] key_kind  [64];
    logic       key_grp   [64];
    logic [63:0] found;
    logic [7:0] window [16];
    int         seen;
    logic       nonempty;
    logic [6:0] thr_ok, thr_part, thr_amb, urg_def;
    t_verdict   verdicts [$];

    function automatic logic [6:0] clip100(input logic [6:0] v);
        return (v > 7'd100) ? 7'd100 : v;
    endfunction

    function automatic logic [1:0] grade(input logic [6:0] s);
        if (s >= thr_ok) return ST_OK;
        if (s >= thr_part) return ST_INC;
        return ST_AMB;
    endfunction

    function automatic bit tail_hit(input int e);
        int n;
        n = key_len[e];
        if (n == 0 || n > 16 || n > seen) return 0;
        for (int i = 0; i < n; i++)
            if (window[16 - n + i] !== key_bytes[e][i]) return 0;
        return 1;
    endfunction

    task automatic leading_intent(output logic [2:0] k, output logic [6:0] s);
        k = 0;
        s = 0;
        for (int e = 0; e < 64; e++)
            if (found[e] && !key_grp[e] && key_pts[e] > s) begin
                s = key_pts[e];
                k = key_kind[e];
            end
    endtask

    task automatic clear_text();
        found = '0;
        foreach (window[i]) window[i] = 8'd0;
        seen = 0;
        nonempty = 0;
    endtask

    task automatic absorb_beat(input logic [1:0] cmd, input logic [39:0] d);
        t_verdict v;
        logic [7:0] b;
        logic [5:0] idx;
        b = d[7:0];
        idx = d[13:8];
        v = '0;
        case (cmd)
            CMD_KEYB: key_bytes[idx][d[17:14]] = b;
            CMD_ATTR: begin
                key_len[idx]  = d[22:18];
                key_pts[idx]  = clip100(d[29:23]);
                key_kind[idx] = d[32:30];
                key_grp[idx]  = d[33];
            end
            CMD_TEXT: begin
                if (b >= 8'h41 && b <= 8'h5A) b = b + 8'd32;
                for (int i = 0; i < 15; i++) window[i] = window[i + 1];
                window[15] = b;
                if (seen < 16) seen++;
                nonempty = 1;
                for (int e = 0; e < 64; e++)
                    if (tail_hit(e)) found[e] = 1;
                leading_intent(v.kind, v.confidence);
                v.status = grade(v.confidence);
                verdicts.push_back(v);
            end
            default: begin
                v.is_final = 1;
                v.urgency  = urg_def;
                if (!nonempty) begin
                    v.status = ST_EMPTY;
                end else begin
                    leading_intent(v.kind, v.confidence);
                    for (int e = 0; e < 64; e++)
                        if (found[e] && key_grp[e]) begin
                            v.urgency = key_pts[e];
                            break;
                        end
                    if (v.confidence < thr_amb) v.questions = (v.kind == 3'd1) ? 2'd2 : 2'd1;
                    v.status = grade(v.confidence);
                    if (found != '0) o_found_seen++;
                end
                verdicts.push_back(v);
                clear_text();
            end
        endcase
    endtask

    task automatic compare_beat();
        t_verdict w;
        t_verdict got;
        got = {i_out_data[1:0], i_out_data[4:2], i_out_data[11:5], i_out_data[18:12],
               i_out_data[20:19], i_out_final};
        if (verdicts.size() == 0) begin
            $error("result beat with nothing expected: %h", i_out_data);
            o_fail_count++;
            return;
        end
        w = verdicts.pop_front();
        if (got.is_final) o_finals_seen++;
        if (got.status !== w.status) begin
            $error("status expected %0d actual %0d", w.status, got.status); o_fail_count++;
        end
        if (got.kind !== w.kind) begin
            $error("kind expected %0d actual %0d", w.kind, got.kind); o_fail_count++;
        end
        if (got.confidence !== w.confidence) begin
            $error("confidence expected %0d actual %0d", w.confidence, got.confidence);
            o_fail_count++;
        end
        if (got.urgency !== w.urgency) begin
            $error("urgency expected %0d actual %0d", w.urgency, got.urgency); o_fail_count++;
        end
        if (got.questions !== w.questions) begin
            $error("clarify_count expected %0d actual %0d", w.questions, got.questions);
            o_fail_count++;
        end
        if (got.is_final !== w.is_final) begin
            $error("is_final expected %0d actual %0d", w.is_final, got.is_final);
            o_fail_count++;
        end
    endtask

    initial begin
        o_fail_count = 0;
        o_finals_seen = 0;
        o_found_seen = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            foreach (key_len[e]) begin
                key_len[e] = 0; key_pts[e] = 0; key_kind[e] = 0; key_grp[e] = 0;
                foreach (key_bytes[e][i]) key_bytes[e][i] = 8'd0;
            end
            clear_text();
            thr_ok = 70; thr_part = 40; thr_amb = 60; urg_def = 50;
            verdicts.delete();
        end else begin
            // The output is compared before the input beat of the same edge is
            // folded in, so a result never meets a prediction it cannot yet have.
            if (i_out_valid && i_out_ready) compare_beat();
            if (i_cfg_we)
                case (i_cfg_index)
                    REG_OK:   thr_ok   = clip100(i_cfg_data);
                    REG_PART: thr_part = clip100(i_cfg_data);
                    REG_AMB:  thr_amb  = clip100(i_cfg_data);
                    default:  urg_def  = clip100(i_cfg_data);
                endcase
            if (i_in_valid && i_in_ready) absorb_beat(i_in_cmd, i_in_data);
        end
        o_pending = verdicts.size();
    end

endmodule

/* test/tb_keyword_dictionary_scorer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_keyword_dictionary_scorer
// Loads dictionaries of random and planted keys, streams mixed-case text
// with end-of-text beats and compares every result with a model kept in
// the checker, under random gaps on both streams and several thresholds.
// ----------------------------------------------------------------------------
module tb_keyword_dictionary_scorer;
    import kds_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_index = REG_OK;
    logic [6:0]  i_cfg_data = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = 0;
    logic [1:0]  s_axis_tuser = CMD_TEXT;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;

    int fail_count, pending, finals_seen, found_seen;
    int cycle_count = 0;
    int beats_sent = 0;
    bit sender_idles = 1;    // random gaps on the input stream
    bit receiver_idles = 1;  // random stalls on the output stream
    bit hold_receiver = 0;   // long stall to back the block up
    // Keys planted in the dictionary, kept so that text can spell them out.
    logic [7:0] planted [64][16];
    int         planted_len [64];

    always #5 i_clk = ~i_clk;

    keyword_dictionary_scorer uut (.*);

    kds_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .i_in_valid(s_axis_tvalid), .i_in_ready(s_axis_tready),
        .i_in_data(s_axis_tdata), .i_in_cmd(s_axis_tuser),
        .i_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_out_data(m_axis_tdata), .i_out_final(m_axis_tuser),
        .o_fail_count(fail_count), .o_pending(pending),
        .o_finals_seen(finals_seen), .o_found_seen(found_seen)
    );

    // Watchdog: stops the run as a failure once it outlasts the slowest run, with
    // stalls on both sides, by a wide margin.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 800000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // The receiver stalls in random bursts, or for a long stretch on request.
    initial begin
        int n;
        forever begin
            @(negedge i_clk);
            if (hold_receiver) begin
                m_axis_tready <= 0;
                repeat (400) @(negedge i_clk);
                hold_receiver = 0;
            end else if (receiver_idles && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 0;
                n = $urandom_range(1, 14);
                repeat (n - 1) @(negedge i_clk);
            end else begin
                m_axis_tready <= 1;
            end
        end
    end

    // One input beat: optional gap, then hold tvalid until it is taken.
    task automatic send(input logic [1:0] cmd, input logic [39:0] d);
        if (sender_idles && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid = 0;
            repeat ($urandom_range(1, 14)) @(negedge i_clk);
        end
        s_axis_tvalid = 1;
        s_axis_tuser  = cmd;
        s_axis_tdata  = d;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        s_axis_tvalid = 0;
        beats_sent++;
    endtask

    task automatic key_byte(input int e, input int p, input logic [7:0] b);
        send(CMD_KEYB, {22'd0, p[3:0], e[5:0], b});
    endtask

    task automatic key_attr(input int e, input int n, input int s, input int k, input bit g);
        send(CMD_ATTR, {6'd0, g, k[2:0], s[6:0], n[4:0], 4'($urandom), e[5:0], 8'($urandom)});
    endtask

    task automatic text(input logic [7:0] b);
        send(CMD_TEXT, {$urandom, b} & 40'h03_FFFF_FFFF);
    endtask

    task automatic end_text();
        send(CMD_END, {$urandom, 8'($urandom)} & 40'h03_FFFF_FFFF);
    endtask

    // Registers change only when nothing is owed and the scan has finished.
    task automatic write_reg(input logic [1:0] r, input logic [6:0] v);
        wait (pending == 0);
        repeat (80) @(negedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= r;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we <= 0;
    endtask

    // Fill every entry, mostly short keys made of a small alphabet so that
    // random text finds them; the rest are noise lengths and scores. Key
    // bytes are written once, later passes only change the attributes.
    task automatic load_dictionary(input int max_len, input bit bytes_too);
        int n;
        for (int e = 0; e < 64; e++) begin
            n = $urandom_range(1, max_len);
            planted_len[e] = n;
            if (bytes_too) begin
                for (int p = 0; p < 16; p++) begin
                    planted[e][p] = ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                    : 8'(8'h61 + $urandom_range(0, 3));
                    key_byte(e, p, planted[e][p]);
                end
            end
            key_attr(e, ($urandom_range(0, 15) == 0) ? $urandom_range(0, 31) : n,
                     $urandom_range(0, 127), $urandom, $urandom_range(0, 3) == 0);
        end
    endtask

    // Text mixes spelled-out keys, with random case, and filler bytes.
    task automatic sentence(input int n);
        int e;
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 2) == 0) begin
                e = $urandom_range(0, 63);
                for (int p = 0; p < planted_len[e]; p++)
                    text($urandom_range(0, 1) && planted[e][p] inside {[8'h61:8'h7A]}
                         ? planted[e][p] - 8'd32 : planted[e][p]);
                i += planted_len[e];
            end else begin
                text($urandom_range(0, 3) == 0 ? 8'($urandom)
                                               : 8'(8'h41 + $urandom_range(0, 35)));
            end
        end
        end_text();
    endtask

    initial begin
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1;

        // Directed: empty end, then extremes of every field on a small dictionary.
        end_text();
        for (int p = 0; p < 16; p++) key_byte(0, p, 8'h61);
        for (int p = 0; p < 16; p++) key_byte(63, p, 8'hFF);
        key_attr(0, 16, 127, 7, 0);   // full length key, score saturated
        key_attr(63, 2, 100, 1, 0);   // kind transform
        key_attr(62, 17, 90, 2, 0);   // too long to ever match
        for (int p = 0; p < 2; p++) key_byte(62, p, 8'h61);
        key_attr(1, 1, 0, 3, 1);      // urgency key of score zero
        for (int p = 0; p < 16; p++) key_byte(1, p, 8'h61);
        key_byte(2, 15, 8'h00);
        text(8'hFF); text(8'hFF); text(8'h41);
        end_text();
        for (int i = 0; i < 16; i++) text(i[0] ? 8'h41 : 8'h61);
        end_text();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin write_reg(REG_OK, 7'd0); write_reg(REG_PART, 7'd0); end
                1: begin write_reg(REG_OK, 7'd127); write_reg(REG_PART, 7'd100);
                         write_reg(REG_AMB, 7'd127); write_reg(REG_URG, 7'd127); end
                2: begin write_reg(REG_AMB, 7'd0); write_reg(REG_URG, 7'd0); end
                default: begin
                    write_reg(REG_OK, 7'($urandom_range(0, 100)));
                    write_reg(REG_PART, 7'($urandom_range(0, 100)));
                    write_reg(REG_AMB, 7'($urandom_range(0, 100)));
                    write_reg(REG_URG, 7'($urandom_range(0, 100)));
                end
            endcase
            load_dictionary(phase == 3 ? 16 : 4, phase == 0);
            if (phase == 1) hold_receiver = 1;   // input backs up behind the stall
            if (phase == 4) begin
                sender_idles = 0;
                receiver_idles = 0;
            end
            for (int s = 0; s < 5; s++) begin
                sentence($urandom_range(3, 40));
                if (s == 3) wait (pending == 0);  // sender pause until drained
            end
        end

        wait (pending == 0);
        repeat (100) @(negedge i_clk);
        $display("Sent %0d beats over five threshold settings; %0d final results,",
                 beats_sent, finals_seen);
        $display("%0d of them with keys found.", found_seen);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

/* sim.f */
sv/kds_pkg.sv
sv/kds_dict.sv
sv/keyword_dictionary_scorer.sv
test/kds_checker.sv
test/tb_keyword_dictionary_scorer.sv
